>>> rtl/core/wav_pcm16_parser_downmix_unit_macros.svh
// assertion macros for the wav parser
`ifndef WAV_PCM16_PARSER_DOWNMIX_UNIT_MACROS_SVH
`define WAV_PCM16_PARSER_DOWNMIX_UNIT_MACROS_SVH
`define WAV_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define WAV_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

>>> rtl/core/wavpd_pkg.sv
// shared types and constants of the wav parser
`timescale 1ns / 1ps
package wavpd_pkg;
   localparam int MaxChannels = 8;
   localparam int ChanIdxW = 4;
   localparam logic [31:0] TagFmt = 32'h2074_6D66;
   localparam logic [31:0] TagData = 32'h6174_6164;
   localparam logic [31:0] TagRiff = 32'h4646_4952;
   localparam logic [31:0] TagWave = 32'h4556_4157;
   localparam logic [2:0] StOk = 3'd0;
   localparam logic [2:0] StHdr = 3'd1;
   localparam logic [2:0] StFmt = 3'd2;
   localparam logic [2:0] StMiss = 3'd3;
   localparam logic [2:0] StOrder = 3'd4;

   // parse phases
   localparam logic [3:0] PhHdr = 4'd0;
   localparam logic [3:0] PhChdr = 4'd1;
   localparam logic [3:0] PhFmt = 4'd2;
   localparam logic [3:0] PhData = 4'd3;
   localparam logic [3:0] PhSkip = 4'd4;
   localparam logic [3:0] PhPad = 4'd5;
   localparam logic [3:0] PhDrain = 4'd6;

   // controller to datapath
   typedef struct packed {
      logic       take;      // consume the captured request byte
      logic       fin;       // build final result
      logic [2:0] fst;
      logic       clr;       // reset file state
   } wavpd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_busy;
      logic out_full;
   } wavpd_sts_type;
endpackage

>>> rtl/core/wavpd_divider.sv
// signed restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module wavpd_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [19:0] dividend,
   input  logic [4:0]  divisor,
   output logic        busy,
   output logic        done,
   output logic [15:0] quotient
);
   import wavpd_pkg::*;
   logic [19:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in, dvs_ff, dvs_in;
   logic        neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [20:0] trial;
   logic [19:0] shifted, res;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; cnt_in = cnt_ff; dvs_in = dvs_ff;
      neg_in = neg_ff; busy_in = busy_ff; done_in = 1'b0;
      shifted = {rem_ff[18:0], quo_ff[19]};
      trial = {1'b0, shifted} - {16'd0, dvs_ff};
      if (start) begin
         neg_in = dividend[19];
         quo_in = dividend[19] ? (~dividend + 20'd1) : dividend;
         rem_in = '0; dvs_in = divisor; cnt_in = 5'd20; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[20]) begin
            rem_in = trial[19:0]; quo_in = {quo_ff[18:0], 1'b1};
         end else begin
            rem_in = shifted; quo_in = {quo_ff[18:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; dvs_ff <= dvs_in; neg_ff <= neg_in;
   end

   assign res = neg_ff ? (~quo_ff + 20'd1) : quo_ff;
   assign quotient = res[15:0];
   assign busy = busy_ff;
   assign done = done_ff;
endmodule

>>> rtl/core/wavpd_datapath.sv
// sample low-byte register, frame accumulator, divider and result queue
`timescale 1ns / 1ps
module wavpd_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  wavpd_pkg::wavpd_cmd_type cmd,
   output wavpd_pkg::wavpd_sts_type sts,
   input  logic [7:0]             byte_d,
   input  logic [3:0]             phase,
   input  logic [31:0]            pos,
   input  logic [15:0]            chan_count,
   input  logic [31:0]            rate_store,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_kind,
   output logic signed [15:0]     rsp_mono_sample,
   output logic [31:0]            rsp_rate_hz,
   output logic [2:0]             rsp_status,
   output logic                   rsp_is_last
);
   import wavpd_pkg::*;
   logic [7:0]  low_ff, low_in;
   logic [19:0] sum_ff, sum_in;
   logic [ChanIdxW-1:0] idx_ff, idx_in;
   logic [19:0] fsum;
   logic        div_start, div_busy, div_done;
   logic [15:0] quo;
   // two entry queue: slot 0 head
   logic [1:0]  v_ff, v_in;
   logic [52:0] q0_ff, q0_in, q1_ff, q1_in;
   logic [52:0] ent_s, ent_f;
   logic        pop;
   logic        fh_v_ff, fh_v_in;
   logic [52:0] fh_ff, fh_in;

   assign fsum = sum_ff + {{4{byte_d[7]}}, byte_d, low_ff};

   always_comb begin
      low_in = low_ff; sum_in = sum_ff; idx_in = idx_ff; div_start = 1'b0;
      if (cmd.take && phase == PhData) begin
         if (!pos[0]) low_in = byte_d;
         else if ({12'd0, idx_ff} + 16'd1 >= chan_count) begin
            div_start = 1'b1; sum_in = '0; idx_in = '0;
         end else begin
            sum_in = fsum; idx_in = idx_ff + 1'b1;
         end
      end
      if (cmd.clr) begin
         sum_in = '0; idx_in = '0;
      end
   end

   wavpd_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(fsum),
      .divisor(chan_count[4:0]), .busy(div_busy), .done(div_done), .quotient(quo)
   );

   assign ent_s = {1'b0, quo, 32'd0, StOk, 1'b0};
   assign ent_f = {1'b1, 16'd0, (cmd.fst == StOk) ? rate_store : 32'd0, cmd.fst, 1'b1};
   assign pop = v_ff[0] && rsp_ready;

   always_comb begin
      v_in = v_ff; q0_in = q0_ff; q1_in = q1_ff; fh_v_in = fh_v_ff; fh_in = fh_ff;
      if (pop) begin
         q0_in = q1_ff; v_in = {1'b0, v_ff[1]};
      end
      // a final result behind a frame divide waits for its sample
      if (div_done) begin
         if (!v_in[0]) begin q0_in = ent_s; v_in[0] = 1'b1; end
         else begin q1_in = ent_s; v_in[1] = 1'b1; end
         if (fh_v_ff) begin
            if (!v_in[0]) begin q0_in = fh_ff; v_in[0] = 1'b1; end
            else begin q1_in = fh_ff; v_in[1] = 1'b1; end
         end
         fh_v_in = 1'b0;
      end
      if (cmd.fin) begin
         if (div_start) begin
            fh_v_in = 1'b1; fh_in = ent_f;
         end else if (!v_in[0]) begin
            q0_in = ent_f; v_in[0] = 1'b1;
         end else begin
            q1_in = ent_f; v_in[1] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0; sum_ff <= '0; idx_ff <= '0; fh_v_ff <= 1'b0;
      end else begin
         v_ff <= v_in; sum_ff <= sum_in; idx_ff <= idx_in; fh_v_ff <= fh_v_in;
      end
      low_ff <= low_in; q0_ff <= q0_in; q1_ff <= q1_in; fh_ff <= fh_in;
   end

   assign sts.div_busy = div_busy || div_done;
   assign sts.out_full = v_ff[0];
   assign rsp_valid = v_ff[0];
   assign rsp_kind = q0_ff[52];
   assign rsp_mono_sample = q0_ff[51:36];
   assign rsp_rate_hz = q0_ff[35:4];
   assign rsp_status = q0_ff[3:1];
   assign rsp_is_last = q0_ff[0];

   `include "wav_pcm16_parser_downmix_unit_macros.svh"
   `WAV_ASSERT_IMP(a_no_overflow, clock, reset, v_ff[1], v_ff[0])
   `WAV_ASSERT_NXT(a_div_done, clock, reset, div_start, div_busy)
   `WAV_ASSERT_IMP(a_start_idle, clock, reset, div_start, !div_busy)
   `WAV_ASSERT_IMP(a_hold_in_divide, clock, reset, fh_v_ff, div_busy || div_done)
endmodule

>>> rtl/core/wavpd_controller.sv
// chunk walking state machine
`timescale 1ns / 1ps
module wavpd_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_last_byte,
   input  wavpd_pkg::wavpd_sts_type sts,
   output wavpd_pkg::wavpd_cmd_type cmd,
   output logic [7:0]             byte_d,
   output logic [3:0]             phase,
   output logic [31:0]            pos,
   output logic [15:0]            chan_count,
   output logic [31:0]            rate_store
);
   import wavpd_pkg::*;
   typedef enum logic [1:0] {S_IDLE, S_EXEC} ctl_type;
   ctl_type     st_ff;
   logic [7:0]  b_ff;
   logic        l_ff;
   logic [3:0]  ph_ff, ph_in;
   logic [31:0] pos_ff, pos_in, tag_ff, tag_in, len_ff, len_in, rate_ff, rate_in;
   logic [15:0] fmt_ff, fmt_in, cc_ff, cc_in, bps_ff, bps_in;
   logic        seen_ff, seen_in, fin, ok;
   logic [2:0]  fst;
   logic [7:0]  exp_b;
   logic [31:0] nxt_pos;

   assign req_ready = (st_ff == S_IDLE) && !sts.out_full && !sts.div_busy;
   assign nxt_pos = pos_ff + 32'd1;

   always_comb begin
      ph_in = ph_ff; pos_in = pos_ff; tag_in = tag_ff; len_in = len_ff;
      rate_in = rate_ff; fmt_in = fmt_ff; cc_in = cc_ff; bps_in = bps_ff;
      seen_in = seen_ff; fin = 1'b0; fst = StOk; ok = 1'b1;
      exp_b = (pos_ff < 32'd4) ? TagRiff[8*pos_ff[1:0] +: 8] : TagWave[8*pos_ff[1:0] +: 8];
      case (ph_ff)
         PhHdr: begin
            if (pos_ff < 32'd4 || (pos_ff >= 32'd8 && pos_ff < 32'd12)) ok = (b_ff == exp_b);
            if (!ok) begin fin = 1'b1; fst = StHdr; end
            else if (pos_ff >= 32'd11) begin ph_in = PhChdr; pos_in = '0; end
            else pos_in = nxt_pos;
         end
         PhChdr: begin
            if (pos_ff < 32'd4) tag_in = {b_ff, tag_ff[31:8]};
            else if (pos_ff == 32'd4) len_in = {24'd0, b_ff};
            else len_in[8*pos_ff[1:0] +: 8] = b_ff;
            if (pos_ff < 32'd7) pos_in = nxt_pos;
            else begin
               pos_in = '0;
               if (tag_ff == TagFmt) begin
                  if (len_in < 32'd16) begin fin = 1'b1; fst = StMiss; end
                  else ph_in = PhFmt;
               end else if (tag_ff == TagData) begin
                  if (!seen_ff) begin fin = 1'b1; fst = StOrder; end
                  else if (len_in == '0) begin fin = 1'b1; fst = StOk; end
                  else ph_in = PhData;
               end else if (len_in != '0) ph_in = PhSkip;
            end
         end
         PhFmt: begin
            case (pos_ff)
               32'd0: fmt_in[7:0] = b_ff;
               32'd1: fmt_in[15:8] = b_ff;
               32'd2: cc_in[7:0] = b_ff;
               32'd3: cc_in[15:8] = b_ff;
               32'd4, 32'd5, 32'd6, 32'd7: rate_in[8*pos_ff[1:0] +: 8] = b_ff;
               32'd14: bps_in[7:0] = b_ff;
               32'd15: bps_in[15:8] = b_ff;
               default: ;
            endcase
            if (nxt_pos == len_ff) begin
               pos_in = '0;
               if (fmt_in == 16'd1 && bps_in == 16'd16 && cc_in >= 16'd1
                   && cc_in <= 16'(MaxChannels)) begin
                  seen_in = 1'b1; ph_in = PhChdr;
               end else begin fin = 1'b1; fst = StFmt; end
            end else pos_in = nxt_pos;
         end
         PhData: begin
            if (nxt_pos == len_ff) begin pos_in = '0; fin = 1'b1; fst = StOk; end
            else pos_in = nxt_pos;
         end
         PhSkip: begin
            if (nxt_pos == len_ff) begin
               pos_in = '0; ph_in = len_ff[0] ? PhPad : PhChdr;
            end else pos_in = nxt_pos;
         end
         PhPad: begin pos_in = '0; ph_in = PhChdr; end
         default: ;
      endcase
      if (fin) ph_in = PhDrain;
      if (!fin && l_ff && ph_in < PhDrain) begin
         fin = 1'b1; fst = (ph_in == PhHdr) ? StHdr : StMiss;
      end
      cmd.take = (st_ff == S_EXEC);
      cmd.fin = (st_ff == S_EXEC) && fin;
      cmd.fst = fst;
      cmd.clr = (st_ff == S_EXEC) && l_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ph_ff <= PhHdr; pos_ff <= '0; tag_ff <= '0; len_ff <= '0;
         rate_ff <= '0; fmt_ff <= '0; cc_ff <= '0; bps_ff <= '0; seen_ff <= 1'b0;
      end else begin
         case (st_ff)
            S_IDLE: if (req_valid && req_ready) st_ff <= S_EXEC;
            S_EXEC: begin
               st_ff <= S_IDLE;
               if (l_ff) begin
                  ph_ff <= PhHdr; pos_ff <= '0; tag_ff <= '0; len_ff <= '0; rate_ff <= '0;
                  fmt_ff <= '0; cc_ff <= '0; bps_ff <= '0; seen_ff <= 1'b0;
               end else begin
                  ph_ff <= ph_in; pos_ff <= pos_in; tag_ff <= tag_in; len_ff <= len_in;
                  rate_ff <= rate_in; fmt_ff <= fmt_in; cc_ff <= cc_in; bps_ff <= bps_in;
                  seen_ff <= seen_in;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
      if (req_valid && req_ready) begin
         b_ff <= req_in_byte; l_ff <= req_last_byte;
      end
   end

   assign byte_d = b_ff;
   assign phase = ph_ff;
   assign pos = pos_ff;
   assign chan_count = cc_ff;
   assign rate_store = rate_ff;

   `include "wav_pcm16_parser_downmix_unit_macros.svh"
   `WAV_ASSERT_NXT(a_exec_after_take, clock, reset, req_valid && req_ready, st_ff == S_EXEC)
   `WAV_ASSERT_IMP(a_no_take_busy, clock, reset, st_ff == S_EXEC, !req_ready)
   `WAV_ASSERT_NXT(a_last_resets, clock, reset, st_ff == S_EXEC && l_ff, ph_ff == PhHdr)
endmodule

>>> rtl/core/wav_pcm16_parser_downmix_unit.sv
// top level of the wav pcm16 parser with mono downmix
// a request is captured, then takes one chunk-walk step in the controller; no new request is taken meanwhile
// a frame's last sample also starts a serial divide that holds off the next request until it is done
// results leave through a two-entry output queue; requests stall while it holds one
// reset is synchronous, active high, and returns the parser to the riff header
`timescale 1ns / 1ps
module wav_pcm16_parser_downmix_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_kind,
   output logic signed [15:0] rsp_mono_sample,
   output logic [31:0]        rsp_rate_hz,
   output logic [2:0]         rsp_status,
   output logic               rsp_is_last
);
   import wavpd_pkg::*;
   wavpd_cmd_type cmd;
   wavpd_sts_type sts;
   logic [7:0]  byte_d;
   logic [3:0]  phase;
   logic [31:0] pos, rate_store;
   logic [15:0] chan_count;

   wavpd_controller u_ctl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_in_byte(req_in_byte), .req_last_byte(req_last_byte), .sts(sts), .cmd(cmd),
      .byte_d(byte_d), .phase(phase), .pos(pos), .chan_count(chan_count),
      .rate_store(rate_store)
   );

   wavpd_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .byte_d(byte_d),
      .phase(phase), .pos(pos), .chan_count(chan_count), .rate_store(rate_store),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_mono_sample(rsp_mono_sample), .rsp_rate_hz(rsp_rate_hz),
      .rsp_status(rsp_status), .rsp_is_last(rsp_is_last)
   );
endmodule

>>> tb/wav_pcm16_parser_downmix_unit_checker.sv
// checker for the wav parser: predicts mono samples and final status, compares responses
`timescale 1ns / 1ps
module wav_pcm16_parser_downmix_unit_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [7:0]         req_in_byte,
   input  logic               req_last_byte,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_kind,
   input  logic signed [15:0] rsp_mono_sample,
   input  logic [31:0]        rsp_rate_hz,
   input  logic [2:0]         rsp_status,
   input  logic               rsp_is_last,
   output int                 fail_count,
   output int                 pending_count
);
   import wavpd_pkg::*;

   typedef enum logic [3:0] {
      PH_HDR = 4'd0, PH_CHDR = 4'd1, PH_FMT = 4'd2, PH_DATA = 4'd3,
      PH_SKIP = 4'd4, PH_PAD = 4'd5, PH_DRAIN = 4'd6
   } parse_phase_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] mono;
      logic [31:0] rate;
      logic [2:0]  status;
      logic        is_last;
   } wav_result_type;

   wav_result_type expected_results[$];

   parse_phase_type phase;
   logic [31:0]  pos_r, tag_r, len_r, rate_r;
   logic [15:0]  fmt_r, chans_r, bits_r;
   logic         fmt_ok_r;
   logic [7:0]   low_r;
   logic [3:0]   cidx_r;
   int           sum_r;

   function automatic logic [7:0] riff_byte(input int i);
      return TagRiff[8*i +: 8];
   endfunction

   function automatic logic [7:0] wave_byte(input int i);
      return TagWave[8*i +: 8];
   endfunction

   task automatic clear_file();
      phase = PH_HDR;
      pos_r = '0; tag_r = '0; len_r = '0; rate_r = '0;
      fmt_r = '0; chans_r = '0; bits_r = '0; fmt_ok_r = 1'b0;
      low_r = '0; cidx_r = '0; sum_r = 0;
   endtask

   task automatic push_result(input logic k, input logic [15:0] m, input logic [31:0] r,
                              input logic [2:0] s, input logic l);
      wav_result_type e;
      e.kind = k; e.mono = m; e.rate = r; e.status = s; e.is_last = l;
      expected_results.push_back(e);
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic lastf);
      logic        fin;
      logic [2:0]  fst;
      logic        ok;
      logic [31:0] pos;
      int          s, sum, cc, sh;
      fin = 1'b0; fst = StOk; pos = pos_r;
      case (phase)
         PH_HDR: begin
            ok = 1'b1;
            if (pos < 4) ok = (b == riff_byte(pos));
            else if (pos >= 8 && pos < 12) ok = (b == wave_byte(pos - 8));
            if (!ok) begin
               fin = 1'b1; fst = StHdr;
            end else if (pos >= 11) begin
               phase = PH_CHDR; pos_r = '0;
            end else pos_r = pos + 1;
         end
         PH_CHDR: begin
            if (pos < 4) tag_r = {b, tag_r[31:8]};
            else if (pos == 4) len_r = {24'd0, b};
            else len_r = len_r | ({24'd0, b} << (8 * ((pos - 4) & 3)));
            if (pos < 7) pos_r = pos + 1;
            else begin
               pos_r = '0;
               if (tag_r == TagFmt) begin
                  if (len_r < 16) begin
                     fin = 1'b1; fst = StMiss;
                  end else phase = PH_FMT;
               end else if (tag_r == TagData) begin
                  if (!fmt_ok_r) begin
                     fin = 1'b1; fst = StOrder;
                  end else if (len_r == 0) begin
                     fin = 1'b1; fst = StOk;
                  end else begin
                     phase = PH_DATA; cidx_r = '0; sum_r = 0;
                  end
               end else if (len_r != 0) phase = PH_SKIP;
            end
         end
         PH_FMT: begin
            if (pos == 0) fmt_r[7:0] = b;
            else if (pos == 1) fmt_r[15:8] = b;
            else if (pos == 2) chans_r[7:0] = b;
            else if (pos == 3) chans_r[15:8] = b;
            else if (pos >= 4 && pos < 8) begin
               sh = 8 * (pos - 4);
               rate_r[sh +: 8] = b;
            end
            else if (pos == 14) bits_r[7:0] = b;
            else if (pos == 15) bits_r[15:8] = b;
            if (pos + 1 == len_r) begin
               pos_r = '0;
               if (fmt_r == 1 && bits_r == 16 && chans_r >= 1 && chans_r <= MaxChannels) begin
                  fmt_ok_r = 1'b1; phase = PH_CHDR;
               end else begin
                  fin = 1'b1; fst = StFmt;
               end
            end else pos_r = pos + 1;
         end
         PH_DATA: begin
            if (!pos[0]) low_r = b;
            else begin
               s = $signed({b, low_r});
               sum = sum_r + s;
               if (32'(cidx_r) + 1 >= 32'(chans_r)) begin
                  cc = (chans_r == 0) ? 1 : int'(chans_r);
                  push_result(1'b0, 16'(sum / cc), '0, StOk, 1'b0);
                  sum_r = 0; cidx_r = '0;
               end else begin
                  sum_r = sum; cidx_r = cidx_r + 1;
               end
            end
            if (pos + 1 == len_r) begin
               pos_r = '0; fin = 1'b1; fst = StOk;
            end else pos_r = pos + 1;
         end
         PH_SKIP: begin
            if (pos + 1 == len_r) begin
               pos_r = '0;
               phase = len_r[0] ? PH_PAD : PH_CHDR;
            end else pos_r = pos + 1;
         end
         PH_PAD: begin
            pos_r = '0; phase = PH_CHDR;
         end
         default: ;
      endcase
      if (fin) begin
         push_result(1'b1, '0, (fst == StOk) ? rate_r : '0, fst, 1'b1);
         phase = PH_DRAIN;
      end
      if (lastf) begin
         if (!fin && phase < PH_DRAIN)
            push_result(1'b1, '0, '0, (phase == PH_HDR) ? StHdr : StMiss, 1'b1);
         clear_file();
      end
   endtask

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      wav_result_type e;
      if (reset) begin
         clear_file();
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (req_valid && req_ready) parse_byte(req_in_byte, req_last_byte);
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response kind=%0d mono=%0d rate=%0d status=%0d",
                        $time, rsp_kind, rsp_mono_sample, rsp_rate_hz, rsp_status);
               fail_count++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_kind !== e.kind || rsp_mono_sample !== e.mono ||
                   rsp_rate_hz !== e.rate || rsp_status !== e.status ||
                   rsp_is_last !== e.is_last) begin
                  $display({"%0t: mismatch expected k=%0d m=%0d r=%0d s=%0d l=%0d",
                            " got k=%0d m=%0d r=%0d s=%0d l=%0d"},
                           $time, e.kind, $signed(e.mono), e.rate, e.status, e.is_last,
                           rsp_kind, rsp_mono_sample, rsp_rate_hz, rsp_status, rsp_is_last);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

>>> tb/wav_pcm16_parser_downmix_unit_tb.sv
// testbench top for the wav parser: builds byte streams of wav files and gives the verdict
`timescale 1ns / 1ps
module wav_pcm16_parser_downmix_unit_tb;
   import wavpd_pkg::*;

   localparam int IdleLimit = 20000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_in_byte = '0;
   logic               req_last_byte = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_kind;
   logic signed [15:0] rsp_mono_sample;
   logic [31:0]        rsp_rate_hz;
   logic [2:0]         rsp_status;
   logic               rsp_is_last;
   int                 fail_count, pending_count;
   int                 idle_cycles = 0;
   logic               hold_rsp = 1'b0;
   int                 burst_left = 0;
   int                 sent_bytes = 0;
   logic [7:0]         file_bytes[$];

   always #2 clock = ~clock;

   wav_pcm16_parser_downmix_unit dut (.*);

   wav_pcm16_parser_downmix_unit_checker chk (.*);

   // receiver stall pattern
   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 7) == 0);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("FAIL wav_pcm16_parser_downmix_unit");
         $finish;
      end
   end

   task automatic send_request(input logic [7:0] b, input logic l);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_last_byte <= l;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_file();
      int n;
      n = file_bytes.size();
      for (int i = 0; i < n; i++)
         send_request(file_bytes[i], i == n - 1);
      sent_bytes += n;
      file_bytes.delete();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic add32(input logic [31:0] v);
      for (int i = 0; i < 4; i++) file_bytes.push_back(v[8*i +: 8]);
   endtask

   task automatic add16(input logic [15:0] v);
      file_bytes.push_back(v[7:0]);
      file_bytes.push_back(v[15:8]);
   endtask

   task automatic add_header();
      add32(TagRiff); add32($urandom); add32(TagWave);
   endtask

   task automatic add_fmt(input logic [31:0] len, input logic [15:0] fmt,
                          input logic [15:0] chans, input logic [31:0] rate,
                          input logic [15:0] bits);
      add32(TagFmt); add32(len);
      add16(fmt); add16(chans); add32(rate); add32($urandom); add16(16'($urandom));
      add16(bits);
      for (int i = 16; i < len; i++) file_bytes.push_back(8'($urandom));
   endtask

   task automatic add_data(input int len, input int mode);
      logic [15:0] v;
      add32(TagData); add32(len);
      for (int i = 0; i < len; i += 2) begin
         case (mode)
            0: v = 16'h7FFF;
            1: v = 16'h8000;
            default: v = 16'($urandom);
         endcase
         file_bytes.push_back(v[7:0]);
         if (i + 1 < len) file_bytes.push_back(v[15:8]);
      end
   endtask

   task automatic add_skip(input int len);
      add32($urandom | 32'h0101_0101); add32(len);
      for (int i = 0; i < len + (len & 1); i++) file_bytes.push_back(8'($urandom));
   endtask

   task automatic wait_drained();
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic random_file();
      int   ch, r;
      r = $urandom_range(0, 19);
      ch = $urandom_range(1, MaxChannels);
      add_header();
      if (r == 0) file_bytes[$urandom_range(0, 11)] = 8'($urandom);
      if ($urandom_range(0, 2) == 0) add_skip($urandom_range(0, 5));
      if (r == 1) add_data(4, 2);
      add_fmt(16 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0),
              (r == 2) ? 16'($urandom) : 16'd1,
              (r == 3) ? 16'($urandom_range(0, 20)) : 16'(ch),
              $urandom, (r == 4) ? 16'($urandom) : 16'd16);
      if ($urandom_range(0, 3) == 0) add_skip($urandom_range(1, 4));
      add_data($urandom_range(0, 6 * ch), 2);
      if (r == 5) repeat ($urandom_range(1, 5)) file_bytes.push_back(8'($urandom));
      if (r == 6) void'(file_bytes.pop_back());
      if (r == 7) file_bytes = file_bytes[0:$urandom_range(0, file_bytes.size() - 1)];
      send_file();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed files
      add_header(); add_fmt(32'd16, 16'd1, 16'd1, 32'hFFFF_FFFF, 16'd16); add_data(4, 0);
      send_file();
      add_header(); add_fmt(32'd16, 16'd1, 16'd8, 32'd0, 16'd16); add_data(16, 1);
      send_file();
      add_header(); add_fmt(32'd18, 16'd1, 16'd2, 32'd44100, 16'd16); add_data(9, 2);
      send_file();
      add_header(); add_fmt(32'd16, 16'd1, 16'd2, 32'd8000, 16'd16); add_data(0, 2);
      send_file();
      add_header(); add_data(4, 2); send_file();
      add_header(); add32(TagFmt); add32(32'd15); send_file();
      add_header(); add_fmt(32'd16, 16'd3, 16'd2, 32'd8000, 16'd16); send_file();
      add_header(); add_fmt(32'd16, 16'd1, 16'd9, 32'd8000, 16'd16); send_file();
      add_header(); add_skip(3); add_fmt(32'd16, 16'd1, 16'd2, 32'd100, 16'd16);
      add_data(4, 2); send_file();
      add32(32'h0000_0000); send_file();
      add32(TagRiff); send_file();
      file_bytes.push_back(8'hFF); send_file();
      wait_drained();
      // long receiver hold while requests keep coming
      hold_rsp = 1'b1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         begin
            add_header(); add_fmt(32'd16, 16'd1, 16'd1, 32'd48000, 16'd16);
            add_data(40, 2); send_file();
         end
      join
      wait_drained();
      while (sent_bytes < 650) begin
         random_file();
         if ($urandom_range(0, 7) == 0) wait_drained();
      end
      wait_drained();
      if (fail_count == 0) $display("PASS wav_pcm16_parser_downmix_unit");
      else $display("FAIL wav_pcm16_parser_downmix_unit");
      $finish;
   end
endmodule
